// File: rtl/pts_pkg.sv
// Shared types, operation codes and helpers for the priority task scheduler.
package pts_pkg;

  // Fixed field widths of the item, configuration and result ports.
  localparam int OP_W   = 3;
  localparam int TASK_W = 4;
  localparam int TICK_W = 16;
  localparam int CNT_W  = 5;
  localparam int PRIO_W = 4;
  localparam int CFG_W  = 64;

  // Operation codes carried by in_operation.
  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_DELAYED  = 3'd1,
    OP_STOP     = 3'd2,
    OP_TICK     = 3'd3,
    OP_DISPATCH = 3'd4
  } op_t;

  // Sequencer states: idle, priority scan, queue compaction, countdown sweep.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIN,
    ST_CMP,
    ST_TICK
  } state_t;

  // Priority of one task taken from the configuration word.
  function automatic logic [PRIO_W-1:0] prio_of(input logic [CFG_W-1:0] prios,
                                                input logic [TASK_W-1:0] id);
    return prios[{id, 2'b00} +: PRIO_W];
  endfunction

endpackage

// File: rtl/priority_task_scheduler.sv
// Priority task scheduler: pending queue and countdowns held in synchronous memories.
// Start, invalid tasks, idle stop/delayed start, empty dispatch, reserved codes: result in the cycle after acceptance.
// Stop or delayed start of a pending task: busy for a compaction pass over the queue, one queue read per entry.
// Tick: busy for a sweep over every task, one countdown memory read per task and a write-back per running task.
// Dispatch: busy for a priority scan over the queue and then a compaction pass.
// Synchronous active-low reset clears control state; queue and counter memories are not cleared.
module priority_task_scheduler #(
  parameter int TASKS      = 16,
  parameter int DELAY_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Item channel
  input  logic                             start,
  output logic                             busy,
  input  logic [pts_pkg::OP_W-1:0]         in_operation,
  input  logic [pts_pkg::TASK_W-1:0]       in_task_id,
  input  logic [pts_pkg::TICK_W-1:0]       in_delay_ticks,
  // Configuration port
  input  logic                             cfg_write_en,
  input  logic [pts_pkg::CFG_W-1:0]        cfg_task_priorities,
  // Result channel
  output logic                             out_strobe,
  output logic                             out_dispatched,
  output logic [pts_pkg::TASK_W-1:0]       out_dispatched_task,
  output logic                             out_empty_error,
  output logic [pts_pkg::CNT_W-1:0]        out_pending_count
);

  localparam int IW   = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int LW   = $clog2(TASKS + 1);
  localparam int DW   = DELAY_BITS;
  localparam int EW   = (DW > pts_pkg::TICK_W) ? DW : pts_pkg::TICK_W;
  localparam int TW   = pts_pkg::TASK_W;
  localparam int OCW  = pts_pkg::CNT_W;
  localparam logic [EW-1:0] DLY_MAX = EW'((64'd1 << DW) - 64'd1);

  // Control and bookkeeping registers.
  pts_pkg::state_t          st_r, st_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic [TASKS-1:0]         pend_r, pend_nxt;
  logic [TASKS-1:0]         run_r, run_nxt;
  logic [IW:0]              a_r, a_nxt;
  logic [IW-1:0]            d_idx_r, d_idx_nxt;
  logic [TW-1:0]            best_id_r, best_id_nxt;
  logic [pts_pkg::PRIO_W-1:0] best_pr_r, best_pr_nxt;
  logic [TW-1:0]            rm_id_r, rm_id_nxt;
  logic                     found_r, found_nxt;
  logic                     disp_r, disp_nxt;
  logic [pts_pkg::CFG_W-1:0] prio_r;

  // Result registers.
  logic                     out_strobe_r, o_strobe_nxt;
  logic                     out_disp_r, o_disp_nxt;
  logic [TW-1:0]            out_task_r, o_task_nxt;
  logic                     out_err_r, o_err_nxt;
  logic [OCW-1:0]           out_cnt_r, o_cnt_nxt;

  // Queue memory: task ids, oldest first.
  logic [TW-1:0]            q_mem [TASKS];
  logic                     q_we, q_re;
  logic [IW-1:0]            q_waddr, q_raddr;
  logic [TW-1:0]            q_wdata, q_rdata_r;

  // Countdown memory: one counter per task.
  logic [DW-1:0]            c_mem [TASKS];
  logic                     c_we, c_re;
  logic [IW-1:0]            c_waddr, c_raddr;
  logic [DW-1:0]            c_wdata, c_rdata_r;

  // Decoded item and helpers.
  pts_pkg::op_t             op;
  logic                     acc;
  logic                     t_ok;
  logic [IW-1:0]            tid;
  logic                     t_pend;
  logic [IW:0]              lim;
  logic                     last;
  logic [EW-1:0]            dly_ext;
  logic [DW-1:0]            dly_sat;
  logic [pts_pkg::PRIO_W-1:0] rd_prio;
  logic                     better;

  assign op      = pts_pkg::op_t'(in_operation);
  assign acc     = start && !busy;
  assign t_ok    = 32'(in_task_id) < TASKS;
  assign tid     = in_task_id[IW-1:0];
  assign t_pend  = pend_r[tid];
  assign dly_ext = EW'(in_delay_ticks);
  assign dly_sat = (dly_ext > DLY_MAX) ? DLY_MAX[DW-1:0] : dly_ext[DW-1:0];
  assign rd_prio = pts_pkg::prio_of(prio_r, q_rdata_r);
  assign better  = (d_idx_r == '0) || (rd_prio < best_pr_r);

  // Scan bound: the sweep covers every task, the queue passes cover the queue.
  assign lim  = (st_r == pts_pkg::ST_TICK) ? (IW+1)'(TASKS) : (IW+1)'(len_r);
  assign last = (({1'b0, d_idx_r} + (IW+1)'(1)) == lim);

  assign busy = (st_r != pts_pkg::ST_IDLE);

  // Next state of the sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pts_pkg::ST_IDLE: begin
        if (acc) begin
          priority case (op)
            pts_pkg::OP_DELAYED,
            pts_pkg::OP_STOP: begin
              if (t_ok && t_pend) st_nxt = pts_pkg::ST_CMP;
            end
            pts_pkg::OP_TICK: st_nxt = pts_pkg::ST_TICK;
            pts_pkg::OP_DISPATCH: begin
              if (len_r != '0) st_nxt = pts_pkg::ST_MIN;
            end
            default: st_nxt = pts_pkg::ST_IDLE;
          endcase
        end
      end
      pts_pkg::ST_MIN: begin
        if (last) st_nxt = pts_pkg::ST_CMP;
      end
      pts_pkg::ST_CMP,
      pts_pkg::ST_TICK: begin
        if (last) st_nxt = pts_pkg::ST_IDLE;
      end
      default: st_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and result values.
  always_comb begin
    len_nxt     = len_r;
    pend_nxt    = pend_r;
    run_nxt     = run_r;
    a_nxt       = a_r;
    d_idx_nxt   = d_idx_r;
    best_id_nxt = best_id_r;
    best_pr_nxt = best_pr_r;
    rm_id_nxt   = rm_id_r;
    found_nxt   = found_r;
    disp_nxt    = disp_r;

    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_re    = 1'b0;
    q_raddr = a_r[IW-1:0];
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    c_re    = 1'b0;
    c_raddr = a_r[IW-1:0];

    o_strobe_nxt = 1'b0;
    o_disp_nxt   = 1'b0;
    o_task_nxt   = '0;
    o_err_nxt    = 1'b0;

    unique case (st_r)
      pts_pkg::ST_IDLE: begin
        if (acc) begin
          // A pass, if one follows, starts by reading entry zero.
          a_nxt     = (IW+1)'(1);
          d_idx_nxt = '0;
          found_nxt = 1'b0;
          disp_nxt  = 1'b0;
          q_raddr   = '0;
          c_raddr   = '0;
          priority case (op)
            pts_pkg::OP_START: begin
              if (t_ok && !t_pend && (len_r < LW'(TASKS))) begin
                q_we          = 1'b1;
                q_waddr       = len_r[IW-1:0];
                q_wdata       = in_task_id;
                len_nxt       = len_r + LW'(1);
                pend_nxt[tid] = 1'b1;
              end
              o_strobe_nxt = 1'b1;
            end
            pts_pkg::OP_DELAYED: begin
              if (t_ok) begin
                c_we         = 1'b1;
                c_waddr      = tid;
                c_wdata      = dly_sat;
                run_nxt[tid] = 1'b1;
              end
              if (t_ok && t_pend) begin
                rm_id_nxt = in_task_id;
                q_re      = 1'b1;
              end else begin
                o_strobe_nxt = 1'b1;
              end
            end
            pts_pkg::OP_STOP: begin
              if (t_ok) run_nxt[tid] = 1'b0;
              if (t_ok && t_pend) begin
                rm_id_nxt = in_task_id;
                q_re      = 1'b1;
              end else begin
                o_strobe_nxt = 1'b1;
              end
            end
            pts_pkg::OP_TICK: begin
              c_re = 1'b1;
            end
            pts_pkg::OP_DISPATCH: begin
              if (len_r != '0) begin
                disp_nxt = 1'b1;
                q_re     = 1'b1;
              end else begin
                o_err_nxt    = 1'b1;
                o_strobe_nxt = 1'b1;
              end
            end
            default: o_strobe_nxt = 1'b1;
          endcase
        end
      end

      pts_pkg::ST_MIN: begin
        // Keep the first entry with the lowest priority value.
        q_re      = (a_r < lim);
        a_nxt     = a_r + (IW+1)'(1);
        d_idx_nxt = a_r[IW-1:0];
        if (better) begin
          best_id_nxt = q_rdata_r;
          best_pr_nxt = rd_prio;
        end
        if (last) begin
          rm_id_nxt = better ? q_rdata_r : best_id_r;
          a_nxt     = (IW+1)'(1);
          d_idx_nxt = '0;
          found_nxt = 1'b0;
          q_re      = 1'b1;
          q_raddr   = '0;
        end
      end

      pts_pkg::ST_CMP: begin
        // Entries behind the removed task each move down by one slot.
        q_re      = (a_r < lim);
        a_nxt     = a_r + (IW+1)'(1);
        d_idx_nxt = a_r[IW-1:0];
        if (found_r) begin
          q_we    = 1'b1;
          q_waddr = d_idx_r - IW'(1);
          q_wdata = q_rdata_r;
        end else if (q_rdata_r == rm_id_r) begin
          found_nxt = 1'b1;
        end
        if (last) begin
          len_nxt                    = len_r - LW'(1);
          pend_nxt[rm_id_r[IW-1:0]]  = 1'b0;
          o_disp_nxt                 = disp_r;
          o_task_nxt                 = disp_r ? rm_id_r : '0;
          o_strobe_nxt               = 1'b1;
        end
      end

      pts_pkg::ST_TICK: begin
        // Visit one task per cycle and count it down if running; expiries join the queue unless already queued.
        c_re      = (a_r < lim);
        a_nxt     = a_r + (IW+1)'(1);
        d_idx_nxt = a_r[IW-1:0];
        if (run_r[d_idx_r]) begin
          c_we    = 1'b1;
          c_waddr = d_idx_r;
          if (c_rdata_r > DW'(1)) begin
            c_wdata = c_rdata_r - DW'(1);
          end else begin
            c_wdata          = '0;
            run_nxt[d_idx_r] = 1'b0;
            if (!pend_r[d_idx_r] && (len_r < LW'(TASKS))) begin
              q_we              = 1'b1;
              q_waddr           = len_r[IW-1:0];
              q_wdata           = TW'(d_idx_r);
              len_nxt           = len_r + LW'(1);
              pend_nxt[d_idx_r] = 1'b1;
            end
          end
        end
        if (last) o_strobe_nxt = 1'b1;
      end

      default: begin
        o_strobe_nxt = 1'b0;
      end
    endcase

    o_cnt_nxt = OCW'(len_nxt);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= pts_pkg::ST_IDLE;
      len_r        <= '0;
      pend_r       <= '0;
      run_r        <= '0;
      prio_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      len_r        <= len_nxt;
      pend_r       <= pend_nxt;
      run_r        <= run_nxt;
      out_strobe_r <= o_strobe_nxt;
      if (cfg_write_en) prio_r <= cfg_task_priorities;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    d_idx_r    <= d_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_pr_r  <= best_pr_nxt;
    rm_id_r    <= rm_id_nxt;
    found_r    <= found_nxt;
    disp_r     <= disp_nxt;
    out_disp_r <= o_disp_nxt;
    out_task_r <= o_task_nxt;
    out_err_r  <= o_err_nxt;
    out_cnt_r  <= o_cnt_nxt;
  end

  // Queue memory with registered read.
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rdata_r <= q_mem[q_raddr];
  end

  // Countdown memory with registered read.
  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_waddr] <= c_wdata;
    if (c_re) c_rdata_r <= c_mem[c_raddr];
  end

  assign out_strobe          = out_strobe_r;
  assign out_dispatched      = out_disp_r;
  assign out_dispatched_task = out_task_r;
  assign out_empty_error     = out_err_r;
  assign out_pending_count   = out_cnt_r;

`ifndef SYNTHESIS
  // The pending flags and the queue length agree whenever no pass is running.
  a_len_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pts_pkg::ST_IDLE) |-> ($countones(pend_r) == 32'(len_r)))
    else $error("pending flags disagree with queue length");

  // A result never reports both a dispatch and an empty queue.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_dispatched && out_empty_error))
    else $error("dispatch and empty error both set");

  // Every multi-cycle item ends with its result.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("pass ended without a result");

  // The queue never holds more tasks than exist.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_pending_count) <= TASKS))
    else $error("pending count exceeds task count");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the priority task scheduler: directed and random item traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_TASKS     = 16;
  localparam int DELAY_BITS    = 16;
  localparam int DELAY_MAX     = (1 << DELAY_BITS) - 1;
  localparam int QUEUE_SLOTS   = 16;
  // Longest busy stretch is a dispatch on a full queue.
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  // Operation codes that the block must ignore.
  localparam logic [pts_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [pts_pkg::OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

  typedef struct packed {
    logic                       dispatched;
    logic [pts_pkg::TASK_W-1:0] task_id;
    logic                       empty_error;
    logic [pts_pkg::CNT_W-1:0]  pending_count;
  } outcome_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [pts_pkg::OP_W-1:0]   in_operation = '0;
  logic [pts_pkg::TASK_W-1:0] in_task_id = '0;
  logic [pts_pkg::TICK_W-1:0] in_delay_ticks = '0;
  logic                       cfg_write_en = 1'b0;
  logic [pts_pkg::CFG_W-1:0]  cfg_task_priorities = '0;
  logic                       out_strobe;
  logic                       out_dispatched;
  logic [pts_pkg::TASK_W-1:0] out_dispatched_task;
  logic                       out_empty_error;
  logic [pts_pkg::CNT_W-1:0]  out_pending_count;

  // Predicted scheduler state.
  logic [pts_pkg::CFG_W-1:0]  prio_word = '0;
  logic [pts_pkg::TASK_W-1:0] ready_q[$];
  logic [NUM_TASKS-1:0]       queued = '0;
  logic [DELAY_BITS-1:0]      countdown[NUM_TASKS];
  logic [NUM_TASKS-1:0]       counting = '0;

  // Outcomes predicted for accepted items, oldest first.
  outcome_t outcome_q[$];
  int       fail_count = 0;

  priority_task_scheduler #(
    .TASKS      (NUM_TASKS),
    .DELAY_BITS (DELAY_BITS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_task_id          (in_task_id),
    .in_delay_ticks      (in_delay_ticks),
    .cfg_write_en        (cfg_write_en),
    .cfg_task_priorities (cfg_task_priorities),
    .out_strobe          (out_strobe),
    .out_dispatched      (out_dispatched),
    .out_dispatched_task (out_dispatched_task),
    .out_empty_error     (out_empty_error),
    .out_pending_count   (out_pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Priority nibble of one task from the current configuration word.
  function automatic logic [pts_pkg::PRIO_W-1:0] task_prio(
      input logic [pts_pkg::TASK_W-1:0] id);
    return prio_word[id * pts_pkg::PRIO_W +: pts_pkg::PRIO_W];
  endfunction

  // Append a task to the back of the queue unless it is already waiting.
  function automatic void enqueue_task(input logic [pts_pkg::TASK_W-1:0] id);
    if (!queued[id] && ready_q.size() < QUEUE_SLOTS) begin
      ready_q.insert(ready_q.size(), id);
      queued[id] = 1'b1;
    end
  endfunction

  // Drop a task from the queue and stop its countdown.
  function automatic void cancel_task(input logic [pts_pkg::TASK_W-1:0] id);
    if (queued[id]) begin
      for (int k = 0; k < ready_q.size(); k++) begin
        if (ready_q[k] == id) begin
          ready_q.delete(k);
          break;
        end
      end
      queued[id] = 1'b0;
    end
    counting[id] = 1'b0;
  endfunction

  // Apply one item to the predicted state and return the outcome it produces.
  function automatic outcome_t advance_schedule(input logic [pts_pkg::OP_W-1:0] op,
                                                input logic [pts_pkg::TASK_W-1:0] id,
                                                input logic [pts_pkg::TICK_W-1:0] ticks);
    outcome_t res;
    int       best;
    res = '0;
    case (op)
      pts_pkg::OP_START: begin
        if (id < NUM_TASKS) enqueue_task(id);
      end
      pts_pkg::OP_DELAYED: begin
        if (id < NUM_TASKS) begin
          cancel_task(id);
          countdown[id] = (ticks > DELAY_MAX) ? DELAY_MAX[DELAY_BITS-1:0] : ticks;
          counting[id] = 1'b1;
        end
      end
      pts_pkg::OP_STOP: begin
        if (id < NUM_TASKS) cancel_task(id);
      end
      pts_pkg::OP_TICK: begin
        // Expiries on one tick are started in ascending task order.
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (counting[i]) begin
            if (countdown[i] > 1) begin
              countdown[i] = countdown[i] - 1'b1;
            end else begin
              countdown[i] = '0;
              counting[i] = 1'b0;
              enqueue_task(i[pts_pkg::TASK_W-1:0]);
            end
          end
        end
      end
      pts_pkg::OP_DISPATCH: begin
        if (ready_q.size() == 0) begin
          res.empty_error = 1'b1;
        end else begin
          // Lowest priority value wins; the strict compare keeps the oldest on ties.
          best = 0;
          for (int k = 1; k < ready_q.size(); k++) begin
            if (task_prio(ready_q[k]) < task_prio(ready_q[best])) best = k;
          end
          res.dispatched = 1'b1;
          res.task_id = ready_q[best];
          queued[ready_q[best]] = 1'b0;
          ready_q.delete(best);
        end
      end
      default: ;
    endcase
    res.pending_count = pts_pkg::CNT_W'(ready_q.size());
    return res;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [pts_pkg::OP_W-1:0] op,
                           input logic [pts_pkg::TASK_W-1:0] id,
                           input logic [pts_pkg::TICK_W-1:0] ticks);
    outcome_t pred;
    in_operation <= op;
    in_task_id <= id;
    in_delay_ticks <= ticks;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pred = advance_schedule(op, id, ticks);
    outcome_q.insert(outcome_q.size(), pred);
  endtask

  // Pause the sender for a number of cycles.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every outcome has arrived and the block is quiet.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load a new priority word while the block is idle.
  task automatic write_priorities(input logic [pts_pkg::CFG_W-1:0] value);
    wait_for_drain();
    cfg_task_priorities <= value;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    prio_word = value;
    cfg_write_en <= 1'b0;
  endtask

  // Dispatch with nothing queued, reserved opcodes and a stop of an idle task.
  task automatic test_empty_queue_and_unused_ops();
    send_item(pts_pkg::OP_DISPATCH, 4'd0, 16'd0);
    send_item(OP_RESERVED_FIRST, 4'd15, 16'hFFFF);
    send_item(OP_RESERVED_LAST, 4'd9, 16'h5A5A);
    send_item(pts_pkg::OP_STOP, 4'd3, 16'd0);
  endtask

  // Priority selection, duplicate start and first-queued tie breaking.
  task automatic test_priority_order();
    write_priorities(64'h3333_3333_0000_000F);
    send_item(pts_pkg::OP_START, 4'd0, 16'd0);
    send_item(pts_pkg::OP_START, 4'd15, 16'd0);
    send_item(pts_pkg::OP_START, 4'd2, 16'd0);
    send_item(pts_pkg::OP_START, 4'd1, 16'd0);
    send_item(pts_pkg::OP_START, 4'd2, 16'd0);
    send_item(pts_pkg::OP_START, 4'd9, 16'd0);
    repeat (4) send_item(pts_pkg::OP_DISPATCH, 4'd0, 16'd0);
  endtask

  // Countdown loading, expiry, cancel by stop and by a second delayed start.
  task automatic test_countdowns();
    send_item(pts_pkg::OP_DELAYED, 4'd4, 16'd0);
    send_item(pts_pkg::OP_DELAYED, 4'd5, 16'd2);
    send_item(pts_pkg::OP_TICK, 4'd0, 16'd0);
    // Task 5 joins the queue while its countdown still runs.
    send_item(pts_pkg::OP_START, 4'd5, 16'd0);
    send_item(pts_pkg::OP_TICK, 4'd0, 16'd0);
    send_item(pts_pkg::OP_DELAYED, 4'd6, 16'hFFFF);
    send_item(pts_pkg::OP_TICK, 4'd0, 16'd0);
    send_item(pts_pkg::OP_STOP, 4'd6, 16'd0);
    // A delayed start of a queued task pulls it out of the queue first.
    send_item(pts_pkg::OP_DELAYED, 4'd4, 16'd1);
    send_item(pts_pkg::OP_TICK, 4'd0, 16'd0);
    repeat (3) send_item(pts_pkg::OP_DISPATCH, 4'd0, 16'd0);
  endtask

  // Random traffic in bursts under one priority setting and operation mix.
  task automatic test_random_traffic(input logic [pts_pkg::CFG_W-1:0] prios,
                                     input int count,
                                     input int start_pct, input int dispatch_pct);
    int                         burst_left;
    int                         r;
    logic [pts_pkg::OP_W-1:0]   op;
    logic [pts_pkg::TICK_W-1:0] ticks;
    write_priorities(prios);
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(9));
        burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
      end
      burst_left--;
      r = $urandom_range(99);
      if (r < start_pct)
        op = pts_pkg::OP_START;
      else if (r < start_pct + dispatch_pct)
        op = pts_pkg::OP_DISPATCH;
      else if (r < start_pct + dispatch_pct + 12)
        op = pts_pkg::OP_DELAYED;
      else if (r < start_pct + dispatch_pct + 20)
        op = pts_pkg::OP_STOP;
      else if (r < start_pct + dispatch_pct + 23)
        op = pts_pkg::OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      else
        op = pts_pkg::OP_TICK;
      // Mostly short countdowns so that they expire; some never do.
      case ($urandom_range(9))
        7: ticks = pts_pkg::TICK_W'($urandom_range(30));
        8: ticks = pts_pkg::TICK_W'($urandom());
        9: ticks = 16'hFFFF;
        default: ticks = pts_pkg::TICK_W'($urandom_range(4));
      endcase
      send_item(op, pts_pkg::TASK_W'($urandom_range(15)), ticks);
    end
  endtask

  // Compare each result with the oldest predicted outcome.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe) begin
      if (outcome_q.size() == 0) begin
        $error("result arrived with no item waiting for it");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_dispatched !== want.dispatched) begin
          $error("dispatched: expected %0d, got %0d", want.dispatched, out_dispatched);
          fail_count++;
        end
        if (out_dispatched_task !== want.task_id) begin
          $error("dispatched_task: expected %0d, got %0d", want.task_id, out_dispatched_task);
          fail_count++;
        end
        if (out_empty_error !== want.empty_error) begin
          $error("empty_error: expected %0d, got %0d", want.empty_error, out_empty_error);
          fail_count++;
        end
        if (out_pending_count !== want.pending_count) begin
          $error("pending_count: expected %0d, got %0d", want.pending_count,
                 out_pending_count);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither an item nor a result moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe)
        quiet = 0;
      else
        quiet++;
    end
    $display("priority_task_scheduler test failed");
    $finish;
  end

  // Reset, then run the tests in turn and report.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue_and_unused_ops();
    test_priority_order();
    test_countdowns();
    test_random_traffic(64'hFFFF_FFFF_FFFF_FFFF, 275, 35, 20);
    test_random_traffic({$urandom(), $urandom()}, 275, 25, 35);
    test_random_traffic(64'h0, 275, 45, 12);
    test_random_traffic(64'hFEDC_BA98_7654_3210, 275, 35, 20);
    wait_for_drain();
    if (outcome_q.size() != 0) begin
      $error("%0d predicted results never arrived", outcome_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("priority_task_scheduler test passed");
    else
      $display("priority_task_scheduler test failed");
    $finish;
  end

endmodule
